### sv/scpa_pkg.sv
// Shared types and constants for the size class pool allocator.
package scpa_pkg;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CLASS = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_NOT_LIVE  = 2'd3;

  localparam logic [1:0] REG_REGION_BASE = 2'd0;
  localparam logic [1:0] REG_FIRST_HUNK  = 2'd1;
  localparam logic [1:0] REG_LATER_HUNK  = 2'd2;
  localparam logic [1:0] REG_CHUNK_NODES = 2'd3;

  localparam int HUNK_SKIP_WORDS = 16;
endpackage

### sv/scpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module scpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/size_class_pool_allocator.sv
// Top level of the size class pool allocator: sequencer over class and link memories.
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/stall   | op, size_bytes, free_address
//   out_    | output    | out_valid/stall  | node_address, status
//   cfg_    | input     | cfg_we           | cfg_index, cfg_data
//
// Accept to out_valid: an alloc from a nonempty list passes class read, decide,
// link read and writeback; a free passes class read and decide; a bad size goes straight to output.
// A refill adds a hunk check step and then a carve step per carved node
// (link memory write port, one per cycle).
// After reset a clearing pass over every class entry zeroes the class memories;
// no input word is taken meanwhile.
// A result sits in an output register; the next word is taken the cycle after it
// has left, so only one word is in the allocator at a time.
module size_class_pool_allocator #(
  parameter int NUM_CLASSES    = 64,
  parameter int MAX_HUNK_COUNT = 16,
  parameter int POOL_WORDS     = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_size_bytes,
  input  logic [31:0] in_free_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_node_address,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CD = (NUM_CLASSES > 1) ? NUM_CLASSES : 2;
  localparam int AW = $clog2(POOL_WORDS);
  localparam int PW = AW + 1;            // word pointers reach POOL_WORDS
  localparam int SW = ((PW > 21) ? PW : 21) + 2;  // hunk sizing sums
  localparam int HW = 5;
  localparam int LW = 21;                // live count width

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_HUNK   = 4'd3;
  localparam logic [3:0] S_CARVE  = 4'd4;
  localparam logic [3:0] S_LREAD  = 4'd5;
  localparam logic [3:0] S_POP    = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;

  logic [3:0] state_r, state_nxt;

  logic [31:0] region_base_r;
  logic [22:0] first_hunk_r, later_hunk_r;
  logic [6:0]  chunk_nodes_r;

  logic          op_r;
  logic [CW-1:0] cls_r;
  logic [AW-1:0] fword_r;
  logic          fvalid_r;

  logic [PW-1:0] bump_r, hunk_end_r;
  logic [HW-1:0] hunks_r;

  logic [PW-1:0] node_r;      // node being carved
  logic [6:0]    cnt_r;       // nodes left to carve
  logic [PW-1:0] head_r;      // head for the pop
  logic [LW-1:0] live_r;
  logic [CW-1:0] clr_r;

  logic        out_valid_r;
  logic [31:0] out_addr_r;
  logic [1:0]  out_st_r;

  // class memories
  logic          hd_we, lv_we;
  logic [CW-1:0] hd_wa, lv_wa, c_ra;
  logic [AW-1:0] hd_wd, hd_rd;
  logic [LW-1:0] lv_wd, lv_rd;
  // link memory
  logic          lk_we;
  logic [AW-1:0] lk_wa, lk_ra, lk_wd, lk_rd;

  scpa_ram #(.WIDTH(AW), .DEPTH(CD)) u_head (
    .clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(c_ra), .rdata(hd_rd));
  scpa_ram #(.WIDTH(LW), .DEPTH(CD)) u_live (
    .clk, .we(lv_we), .waddr(lv_wa), .wdata(lv_wd), .raddr(c_ra), .rdata(lv_rd));
  scpa_ram #(.WIDTH(AW), .DEPTH(POOL_WORDS)) u_link (
    .clk, .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));

  // input decode
  logic [7:0]    size_m1;
  logic [CW-1:0] cls_in;
  logic          bad_class;
  logic [31:0]   foff;
  logic [29:0]   fw_full;
  assign size_m1   = in_size_bytes - 8'd1;
  assign cls_in    = CW'(size_m1[7:2]);
  assign bad_class = (in_size_bytes == 8'd0) ||
                     (32'(size_m1[7:2]) >= 32'(NUM_CLASSES));
  assign foff      = in_free_address - region_base_r;
  assign fw_full   = foff[31:2];

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  logic take;
  assign take = in_valid && !in_stall;

  // refill sizing
  logic [CW:0]   wsize;
  logic [6:0]    nodes;
  logic [15:0]   need;
  logic [SW-1:0] bump_need, hunk_bytes_w, new_end, new_bump_need;
  assign wsize  = {1'b0, cls_r} + 1'b1;
  assign nodes  = (chunk_nodes_r == 7'd0) ? 7'd1 : chunk_nodes_r;
  assign need   = 16'(wsize) * 16'(nodes);
  assign bump_need = SW'(bump_r) + SW'(need);
  assign hunk_bytes_w = (hunks_r == '0) ? SW'(first_hunk_r[22:2])
                                        : SW'(later_hunk_r[22:2]);
  assign new_end = SW'(hunk_end_r) + hunk_bytes_w;
  assign new_bump_need = SW'(hunk_end_r) + SW'(scpa_pkg::HUNK_SKIP_WORDS) + SW'(need);

  always_comb begin
    state_nxt = state_r;
    hd_we = 1'b0; hd_wa = cls_r; hd_wd = '0;
    lv_we = 1'b0; lv_wa = cls_r; lv_wd = '0;
    lk_we = 1'b0; lk_wa = node_r[AW-1:0]; lk_wd = '0;
    lk_ra = head_r[AW-1:0];
    c_ra  = cls_in;
    case (state_r)
      S_CLEAR: begin
        hd_we = 1'b1; hd_wa = clr_r; lv_we = 1'b1; lv_wa = clr_r;
        if (clr_r == CW'(CD-1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (take) state_nxt = bad_class ? S_OUT : S_DEC;
      S_DEC: begin
        if (op_r == scpa_pkg::OP_FREE) begin
          if (fvalid_r && lv_rd != '0) begin
            lk_we = 1'b1; lk_wa = fword_r; lk_wd = hd_rd;
            hd_we = 1'b1; hd_wd = fword_r;
            lv_we = 1'b1; lv_wd = lv_rd - 1'b1;
          end
          state_nxt = S_OUT;
        end else if (hd_rd == '0) state_nxt = S_HUNK;
        else state_nxt = S_LREAD;
      end
      S_HUNK: begin
        if (bump_need <= SW'(hunk_end_r)) state_nxt = S_CARVE;
        else if (32'(hunks_r) >= 32'(MAX_HUNK_COUNT) ||
                 new_end > SW'(POOL_WORDS) || new_bump_need > new_end)
          state_nxt = S_OUT;
        else state_nxt = S_CARVE;
      end
      S_CARVE: begin
        lk_we = 1'b1;
        lk_wd = (cnt_r == 7'd1) ? '0 : AW'(node_r + PW'(wsize));
        if (cnt_r == 7'd1) state_nxt = S_LREAD;
      end
      S_LREAD: state_nxt = S_POP;
      S_POP: begin
        hd_we = 1'b1; hd_wd = lk_rd;
        lv_we = 1'b1; lv_wd = live_r + 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      bump_r <= '0; hunk_end_r <= '0; hunks_r <= '0;
      region_base_r <= 32'd65536;
      first_hunk_r <= 23'd1024;
      later_hunk_r <= 23'd102400;
      chunk_nodes_r <= 7'd20;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          scpa_pkg::REG_REGION_BASE: region_base_r <= cfg_data;
          scpa_pkg::REG_FIRST_HUNK:  first_hunk_r  <= cfg_data[22:0];
          scpa_pkg::REG_LATER_HUNK:  later_hunk_r  <= cfg_data[22:0];
          scpa_pkg::REG_CHUNK_NODES: chunk_nodes_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (take) begin
          op_r <= in_op;
          cls_r <= cls_in;
          fword_r <= fw_full[AW-1:0];
          fvalid_r <= (fw_full != '0) && (32'(fw_full) < 32'(POOL_WORDS));
          out_addr_r <= '0;
          out_st_r <= bad_class ? scpa_pkg::ST_BAD_CLASS : scpa_pkg::ST_OK;
        end
        S_DEC: begin
          head_r <= PW'(hd_rd);
          live_r <= lv_rd;
          if (op_r == scpa_pkg::OP_FREE && fvalid_r && lv_rd == '0)
            out_st_r <= scpa_pkg::ST_NOT_LIVE;
        end
        S_HUNK: begin
          cnt_r <= nodes;
          if (bump_need <= SW'(hunk_end_r)) begin
            node_r <= bump_r; head_r <= bump_r;
            bump_r <= PW'(bump_need);
          end else if (32'(hunks_r) >= 32'(MAX_HUNK_COUNT) ||
                       new_end > SW'(POOL_WORDS) || new_bump_need > new_end) begin
            out_st_r <= scpa_pkg::ST_EXHAUSTED;
          end else begin
            hunk_end_r <= PW'(new_end);
            node_r <= PW'(hunk_end_r + PW'(scpa_pkg::HUNK_SKIP_WORDS));
            head_r <= PW'(hunk_end_r + PW'(scpa_pkg::HUNK_SKIP_WORDS));
            bump_r <= PW'(new_bump_need);
            hunks_r <= hunks_r + 1'b1;
          end
        end
        S_CARVE: begin
          node_r <= node_r + PW'(wsize);
          cnt_r <= cnt_r - 1'b1;
        end
        S_POP: out_addr_r <= region_base_r + (32'(head_r) << 2);
        S_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_node_address = out_addr_r;
  assign out_status       = out_st_r;
endmodule

### dv/tb.sv
// Testbench for the size class pool allocator: directed and random alloc/free traffic.
module tb;
  localparam int NCLS  = 64;
  localparam int MAXH  = 16;
  localparam int PWORDS = 1048576;
  localparam int IDLE_LIMIT = 200000;

  // Expected-result store plus its own allocator state, updated per accepted word.
  class alloc_scoreboard;
    logic [31:0] base_addr;
    logic [22:0] first_bytes, later_bytes;
    logic [6:0]  chunk_nodes;
    logic [20:0] head [NCLS];
    logic [20:0] live [NCLS];
    logic [20:0] links [int];
    int unsigned bump, hunk_end, hunks;
    logic [31:0] want_addr [$];
    logic [1:0]  want_st [$];
    int errors;

    function void clear();
      base_addr = 32'h10000; first_bytes = 1024; later_bytes = 102400; chunk_nodes = 20;
      foreach (head[i]) begin head[i] = 0; live[i] = 0; end
      links.delete(); bump = 0; hunk_end = 0; hunks = 0; errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] d);
      case (idx)
        scpa_pkg::REG_REGION_BASE: base_addr = d;
        scpa_pkg::REG_FIRST_HUNK:  first_bytes = d[22:0];
        scpa_pkg::REG_LATER_HUNK:  later_bytes = d[22:0];
        default:                   chunk_nodes = d[6:0];
      endcase
    endfunction

    // carve a chunk onto an empty class list; 0 when no room
    function bit carve(int cls);
      int unsigned w, n, need, bytes, start, nend, nbump;
      w = cls + 1;
      n = (chunk_nodes == 0) ? 1 : chunk_nodes;
      need = w * n;
      if (bump + need > hunk_end) begin
        if (hunks >= MAXH) return 0;
        bytes = hunks ? later_bytes : first_bytes;
        start = hunk_end;
        nend = start + (bytes >> 2);
        nbump = start + scpa_pkg::HUNK_SKIP_WORDS;
        if (nend > PWORDS || nbump + need > nend) return 0;
        hunk_end = nend; bump = nbump; hunks++;
      end
      for (int i = 0; i < n; i++)
        links[bump + i * w] = (i + 1 < n) ? bump + (i + 1) * w : 0;
      head[cls] = bump;
      bump += need;
      return 1;
    endfunction

    function void note_word(logic op, logic [7:0] sz, logic [31:0] fa);
      int cls;
      logic [31:0] a, wd;
      int unsigned node;
      a = 0;
      if (sz == 0 || ((sz - 1) >> 2) >= NCLS) begin
        want_addr.push_back(0); want_st.push_back(scpa_pkg::ST_BAD_CLASS); return;
      end
      cls = (sz - 1) >> 2;
      if (op == scpa_pkg::OP_ALLOC) begin
        if (head[cls] == 0 && !carve(cls)) begin
          want_addr.push_back(0); want_st.push_back(scpa_pkg::ST_EXHAUSTED); return;
        end
        node = head[cls];
        head[cls] = links.exists(node) ? links[node] : 21'd0;
        live[cls] = live[cls] + 1;
        a = base_addr + node * 4;
        want_addr.push_back(a); want_st.push_back(scpa_pkg::ST_OK);
      end else begin
        wd = (fa - base_addr) >> 2;
        if (wd == 0 || wd >= PWORDS) begin
          want_addr.push_back(0); want_st.push_back(scpa_pkg::ST_OK); return;
        end
        if (live[cls] == 0) begin
          want_addr.push_back(0); want_st.push_back(scpa_pkg::ST_NOT_LIVE); return;
        end
        links[wd] = head[cls];
        head[cls] = 21'(wd);
        live[cls] = live[cls] - 1;
        want_addr.push_back(0); want_st.push_back(scpa_pkg::ST_OK);
      end
    endfunction

    function void check_word(logic [31:0] a, logic [1:0] st);
      if (want_st.size() == 0) begin
        $error("result with nothing expected: addr %h status %0d", a, st);
        errors++; return;
      end
      if (a !== want_addr[0]) begin
        $error("node_address: expected %h, got %h", want_addr[0], a); errors++;
      end
      if (st !== want_st[0]) begin
        $error("status: expected %0d, got %0d", want_st[0], st); errors++;
      end
      void'(want_addr.pop_front()); void'(want_st.pop_front());
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_op;
  logic [7:0] in_size_bytes;
  logic [31:0] in_free_address;
  logic out_valid, out_stall;
  logic [31:0] out_node_address;
  logic [1:0] out_status;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  alloc_scoreboard sb;
  int idle_cycles;
  bit drain_stall;  // receiver stall enable; stays set for the whole run
  logic [31:0] handed [$];  // live node addresses, candidates for free
  logic [7:0]  handed_sz [$];

  size_class_pool_allocator dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Sample at the rising edge; notes input words, checks results and stops on an idle timeout.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_op, in_size_bytes, in_free_address);
      if (out_valid && !out_stall) begin
        sb.check_word(out_node_address, out_status);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Track live allocations from results so frees name real nodes.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_status == scpa_pkg::ST_OK
        && out_node_address != 0 && sb.want_st.size() >= 0 && handed.size() < 4000) begin
      handed.push_back(out_node_address);
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Receiver stall: random stretches, short mostly.
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      out_stall = drain_stall && (gap_len() > 1);
    end
  end

  task automatic send_word(logic op, logic [7:0] sz, logic [31:0] fa);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk);
    in_op = op; in_size_bytes = sz; in_free_address = fa; in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = d;
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic wait_idle();
    while (sb.want_st.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Free a node handed out earlier, with a random size from 1 to 64.
  task automatic free_some();
    int k;
    logic [31:0] a;
    k = $urandom_range(0, handed.size() - 1);
    a = handed[k];
    handed.delete(k);
    send_word(scpa_pkg::OP_FREE, $urandom_range(1, 64), a);
  endtask

  task automatic random_phase(int n, int maxsz);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) send_word(scpa_pkg::OP_ALLOC, $urandom_range(1, maxsz), $urandom);
      else if (r < 85 && handed.size() > 0) free_some();
      else if (r < 92) send_word(scpa_pkg::OP_FREE, $urandom_range(1, 255), $urandom);
      else send_word($urandom_range(0, 1), $urandom_range(0, 255), $urandom);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_n = 0; in_valid = 0; in_op = 0; in_size_bytes = 0; in_free_address = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0; idle_cycles = 0; drain_stall = 1;
    repeat (6) @(negedge clk);
    rst_n = 1;

    // directed: reset config, size extremes, both ops, error cases
    send_word(scpa_pkg::OP_ALLOC, 0, 0);
    send_word(scpa_pkg::OP_ALLOC, 255, 0);
    send_word(scpa_pkg::OP_ALLOC, 1, 0);
    send_word(scpa_pkg::OP_ALLOC, 4, 32'hFFFF_FFFF);
    send_word(scpa_pkg::OP_ALLOC, 5, 0);
    send_word(scpa_pkg::OP_ALLOC, 8, 0);
    send_word(scpa_pkg::OP_FREE, 200, 32'h0001_0040);
    send_word(scpa_pkg::OP_FREE, 9, 32'h0001_0100);
    send_word(scpa_pkg::OP_FREE, 1, 32'h0001_0000);
    send_word(scpa_pkg::OP_FREE, 1, 32'h0000_0000);
    send_word(scpa_pkg::OP_FREE, 1, 32'h0041_0000);
    send_word(scpa_pkg::OP_FREE, 0, 32'h0001_0040);
    send_word(scpa_pkg::OP_ALLOC, 253, 0);
    send_word(scpa_pkg::OP_ALLOC, 256 - 1, 0);
    send_word(scpa_pkg::OP_ALLOC, 252, 0);
    send_word(scpa_pkg::OP_ALLOC, 250, 0);
    send_word(scpa_pkg::OP_FREE, 252, 32'h0001_0000 + 4 * 16);
    wait_idle();

    // phase: tiny hunks, chunk count of zero (acts as one), high base
    write_reg(scpa_pkg::REG_REGION_BASE, 32'hFFFF_FFFC);
    write_reg(scpa_pkg::REG_FIRST_HUNK, 128);
    write_reg(scpa_pkg::REG_LATER_HUNK, 128);
    write_reg(scpa_pkg::REG_CHUNK_NODES, 0);
    handed.delete();
    random_phase(300, 64);
    wait_idle();

    // phase: chunk count of 64, hunks the size of the whole pool
    write_reg(scpa_pkg::REG_REGION_BASE, 4);
    write_reg(scpa_pkg::REG_FIRST_HUNK, 4194304);
    write_reg(scpa_pkg::REG_LATER_HUNK, 4194304);
    write_reg(scpa_pkg::REG_CHUNK_NODES, 64);
    handed.delete();
    random_phase(500, 255);
    wait_idle();

    // phase: medium hunk sizes, chunk count of three, random base
    write_reg(scpa_pkg::REG_REGION_BASE, $urandom & 32'hFFFF_FFFC);
    write_reg(scpa_pkg::REG_FIRST_HUNK, 4096);
    write_reg(scpa_pkg::REG_LATER_HUNK, 8192);
    write_reg(scpa_pkg::REG_CHUNK_NODES, 3);
    handed.delete();
    random_phase(500, 128);
    wait_idle();

    write_reg(scpa_pkg::REG_CHUNK_NODES, 127);
    write_reg(scpa_pkg::REG_REGION_BASE, 32'h0001_0000);
    handed.delete();
    random_phase(530, 32);

    while (sb.want_st.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
